// ===== hw/rtl/fsa_pkg.sv =====
// Shared types, widths and codes for the free-list slot allocator.
`timescale 1ns / 1ps

package fsa_pkg;

  // Default pool size and the slot count loaded at reset.
  localparam int MAX_SLOTS_DEF    = 4096;
  localparam int RESET_SLOT_COUNT = 4096;

  // Field widths of the request and result words.
  localparam int SLOT_W   = 12;
  localparam int CNT_W    = 13;
  localparam int STATUS_W = 2;

  // Stream word widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_FLDS_W = SLOT_W + 3 * CNT_W;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLDS_W;

  // Saturation limit of the in-use counter.
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Request kinds.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep;   // write one entry of the initial chain
    logic take;    // a request word is accepted this cycle
    logic finish;  // the link of the popped slot is ready
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_done;  // the sweep is at the last entry
    logic need_pop;    // the waiting request is an allocate on a non-empty list
    logic out_busy;    // the result register holds a word that is not taken
  } sts_t;

endpackage

// ===== hw/rtl/free_list_slot_allocator.sv =====
// Top level of the free-list slot allocator: controller and datapath.
//
// Requests arrive on the s_ stream: s_tuser is the kind (0 allocate, 1 free)
// and s_tdata carries the slot to free. Each request gives one result word
// on the m_ stream: m_tuser is the status (0 ok, 1 pool exhausted, 2 slot out
// of range) and m_tdata carries the granted slot and the in-use, free and
// high-water counts after the request.
// The slot count register is written through cfg_we and cfg_data; the user
// must write it only while no request is outstanding, as the block does not
// enforce this. A write rebuilds the free list as slots 0 upwards in
// ascending order and clears the counts. The result of a free, or of a
// refused request, is valid on the cycle after acceptance. An allocate goes
// through the pop state, as the link of the head slot comes from the single
// registered read port of the link memory. The next request is accepted once
// the previous one is done and its result word has left or leaves in that
// cycle, so frees can follow one a cycle while results are taken. After
// reset and after every register write a clearing sweep writes the initial
// chain into all MAX_SLOTS link memory entries, one entry a cycle; s_tready
// stays low until it ends. When the receiver stalls, the result is held and
// s_tready stays low until the word is taken.
`timescale 1ns / 1ps

module free_list_slot_allocator #(
  parameter int MAX_SLOTS = fsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsa_pkg::CNT_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fsa_pkg::IN_DATA_W-1:0]   s_tdata,   // [11:0] slot_index
  input  logic                            s_tuser,   // [0] op
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsa_pkg::OUT_DATA_W-1:0]  m_tdata,   // [11:0] granted_slot, [24:12] used_count,
                                                      // [37:25] free_count, [50:38] high_water
  output logic [fsa_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);

  import fsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of sweep, requests and pops.
  fsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // List storage, counters and result register.
  fsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// ===== hw/rtl/fsa_ctrl.sv =====
// Controller state machine: clearing sweep, request acceptance and pop completion.
`timescale 1ns / 1ps

module fsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  fsa_pkg::sts_t sts,
  output fsa_pkg::cmd_t cmd
);

  import fsa_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_POP   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  // A request is taken only when idle and the result register will be free.
  assign s_tready = (state == ST_IDLE) && !sts.out_busy;
  assign take     = s_tvalid && s_tready;

  assign cmd.sweep  = (state == ST_CLEAR);
  assign cmd.take   = take;
  assign cmd.finish = (state == ST_POP);

  // Next state; a register write always restarts the sweep.
  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = ST_CLEAR;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (sts.sweep_done) state_next = ST_IDLE;
        end
        ST_IDLE: begin
          if (take && sts.need_pop) state_next = ST_POP;
        end
        ST_POP: begin
          state_next = ST_IDLE;
        end
        default: begin
          state_next = ST_CLEAR;
        end
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // An allocate on a non-empty list always enters the pop state to wait for its link.
  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    (take && sts.need_pop && !cfg_we) |=> (state == ST_POP))
    else $error("allocate with a read did not enter the pop state");

  // The pop state is never held.
  a_pop_single: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP) |=> (state != ST_POP))
    else $error("pop state held for more than one cycle");

  // A register write rebuilds the list before any request is taken.
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (state == ST_CLEAR) && !s_tready)
    else $error("register write did not start the clearing sweep");

endmodule

// ===== hw/rtl/fsa_datapath.sv =====
// Datapath: link memory, head pointer, counters and the result register.
`timescale 1ns / 1ps

module fsa_datapath #(
  parameter int MAX_SLOTS = fsa_pkg::MAX_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fsa_pkg::CNT_W-1:0]       cfg_data,
  input  logic [fsa_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fsa_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [fsa_pkg::STATUS_W-1:0]    m_tuser,
  input  fsa_pkg::cmd_t                   cmd,
  output fsa_pkg::sts_t                   sts
);

  import fsa_pkg::*;

  localparam int IDX_W     = $clog2(MAX_SLOTS);
  localparam int LINK_W    = $clog2(MAX_SLOTS + 1);
  localparam int RST_COUNT = (RESET_SLOT_COUNT > MAX_SLOTS) ? MAX_SLOTS : RESET_SLOT_COUNT;

  localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(MAX_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(MAX_SLOTS - 1);
  localparam logic [CNT_W-1:0]  RST_CNT   = CNT_W'(RST_COUNT);

  // Link memory: one next link per slot, the end mark terminates the list.
  logic [LINK_W-1:0] links [MAX_SLOTS];
  logic [LINK_W-1:0] rd_data;

  logic [CNT_W-1:0]  pool_size;
  logic [CNT_W-1:0]  cfg_count;
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] head_next;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  used_next;
  logic [CNT_W-1:0]  peak;
  logic [CNT_W-1:0]  peak_next;
  logic [CNT_W-1:0]  free_next;
  logic [IDX_W-1:0]  sweep_addr;
  logic [LINK_W-1:0] sweep_plus;
  logic [LINK_W-1:0] sweep_link;

  logic [SLOT_W-1:0] req_slot;
  logic              list_empty;
  logic              in_range;
  logic              rd_en;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [LINK_W-1:0] mem_wd;

  logic                load_out;
  logic [STATUS_W-1:0] res_status;
  logic [SLOT_W-1:0]   res_granted;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_granted;
  logic [CNT_W-1:0]    out_used;
  logic [CNT_W-1:0]    out_free;
  logic [CNT_W-1:0]    out_high;

  // Requested slot count, saturated to MAX_SLOTS.
  assign cfg_count = (cfg_data > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : cfg_data;

  // Link value of the initial ascending chain at the sweep address.
  assign sweep_plus = LINK_W'(sweep_addr) + LINK_W'(1);
  assign sweep_link = (sweep_plus < pool_size) ? sweep_plus : LINK_END;

  assign req_slot   = s_tdata[SLOT_W-1:0];
  assign list_empty = (head >= LINK_END);
  assign in_range   = ({1'b0, req_slot} < pool_size);
  assign rd_en      = cmd.take && sts.need_pop;

  assign sts.sweep_done = (sweep_addr == LAST_IDX);
  assign sts.need_pop   = (s_tuser == OP_ALLOC) && !list_empty;
  assign sts.out_busy   = out_valid && !m_tready;

  // Request handling: sweep writes, pushes, pops and rejected requests.
  always_comb begin
    head_next   = head;
    used_next   = used;
    res_status  = STAT_OK;
    res_granted = '0;
    load_out    = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = sweep_addr;
    mem_wd      = sweep_link;
    if (cmd.sweep) begin
      mem_we = 1'b1;
    end else if (cmd.finish) begin
      head_next   = rd_data;
      res_granted = SLOT_W'(head);
      used_next   = (used != COUNT_MAX) ? used + CNT_W'(1) : used;
      load_out    = 1'b1;
    end else if (cmd.take && !sts.need_pop) begin
      load_out = 1'b1;
      if (s_tuser == OP_FREE) begin
        if (in_range) begin
          mem_we    = 1'b1;
          mem_wa    = IDX_W'(req_slot);
          mem_wd    = head;
          head_next = LINK_W'(req_slot);
          used_next = (used != '0) ? used - CNT_W'(1) : used;
        end else begin
          res_status = STAT_RANGE;
        end
      end else begin
        res_status = STAT_EXHAUSTED;
      end
    end
    peak_next = (used_next > peak) ? used_next : peak;
    free_next = (pool_size > used_next) ? pool_size - used_next : '0;
  end

  // List state; reset and register writes rebuild it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size  <= RST_CNT;
      head       <= (RST_CNT != '0) ? '0 : LINK_END;
      used       <= '0;
      peak       <= '0;
      sweep_addr <= '0;
    end else if (cfg_we) begin
      pool_size  <= cfg_count;
      head       <= (cfg_count != '0) ? '0 : LINK_END;
      used       <= '0;
      peak       <= '0;
      sweep_addr <= '0;
    end else begin
      head <= head_next;
      used <= used_next;
      peak <= peak_next;
      if (cmd.sweep) sweep_addr <= sweep_addr + IDX_W'(1);
    end
  end

  // Link memory: one write port, one registered read port at the head.
  always_ff @(posedge clk) begin
    if (mem_we) links[mem_wa] <= mem_wd;
    if (rd_en) rd_data <= links[head[IDX_W-1:0]];
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status  <= res_status;
      out_granted <= res_granted;
      out_used    <= used_next;
      out_free    <= free_next;
      out_high    <= peak_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_high, out_free, out_used, out_granted};

  // A popped link never lands on a result that is still waiting.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_valid)
    else $error("pop completed while the result register was occupied");

  // Requests that need no read give their result on the next cycle.
  a_direct_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && !sts.need_pop && !cfg_we) |=> out_valid)
    else $error("direct request produced no result");

  // The in-use count moves only when a request completes.
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    (!cfg_we && !cmd.finish && !cmd.take) |=> $stable(used))
    else $error("in-use count changed without a request");

endmodule
